/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the vector alignment block.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define VARA_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define VARA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/vara_pkg.sv */
// Shared constants, types and tables for the vector alignment pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package vara_pkg;

  localparam int IN_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF = 14;

  // Unit vectors are Q30
  localparam int UNIT_SH = 30;
  localparam int UNIT_W  = 32;

  // Normalization datapath
  localparam int SH_W    = 32;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = 32;
  localparam int UDIV_NW = 63;
  localparam int UDIV_QW = 31;

  // Matrix datapath
  localparam int V_W     = 34;
  localparam int PROD_W  = 68;
  localparam int FS_W    = 34;
  localparam int QDIV_NW = 64;
  localparam int QDIV_DW = 32;
  localparam int QDIV_QW = 32;
  localparam int Q_W     = 34;
  localparam int TERM_W  = 68;
  localparam int ACC_W   = 72;

  // Pipeline depths
  localparam int NORM_LAT = 69;
  localparam int MAT_LAT  = 41;

  // Row-major matrix element tables: cross matrix sign and component,
  // and which quadratic term (00, 11, 22, 01, 02, 12) the element uses
  localparam int VX_SIGN [9]  = '{0, -1, 1, 1, 0, -1, -1, 1, 0};
  localparam int VX_COMP [9]  = '{0, 2, 1, 2, 0, 0, 1, 0, 0};
  localparam int TERM_IDX [9] = '{0, 3, 4, 3, 1, 5, 4, 5, 2};

  typedef struct packed {
    logic ident;
    logic zero;
  } flags_t;

  // Number of significant bits of x
  function automatic logic [6:0] bitlen64(input logic [63:0] x);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/vara_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on vara_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module vara_isqrt import vara_pkg::*; (
  input  logic              clk,
  input  logic [SQ_W-1:0]   x,
  output logic [ROOT_W-1:0] root
);

  logic [SQ_W-1:0] rem_s [0:ROOT_W];
  logic [SQ_W-1:0] res_s [0:ROOT_W];

  assign rem_s[0] = x;
  assign res_s[0] = '0;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * i);
    logic [SQ_W-1:0] trial;
    assign trial = res_s[i] + BIT;

    // Try the next bit and keep it if the remainder allows
    always_ff @(posedge clk) begin
      if (rem_s[i] >= trial) begin
        rem_s[i+1] <= rem_s[i] - trial;
        res_s[i+1] <= (res_s[i] >> 1) + BIT;
      end else begin
        rem_s[i+1] <= rem_s[i];
        res_s[i+1] <= res_s[i] >> 1;
      end
    end
  end

  assign root = res_s[ROOT_W][ROOT_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/vara_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Needs num >> QW below den. Depends on vara_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

module vara_div import vara_pkg::*; #(
  parameter int NW = UDIV_NW,
  parameter int DW = ROOT_W,
  parameter int QW = UDIV_QW
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_s [0:QW];
  logic [QW-1:0] low_s [0:QW];
  logic [DW-1:0] den_s [0:QW];
  logic [QW-1:0] quo_s [0:QW];

  assign rem_s[0] = DW'(num[NW-1:QW]);
  assign low_s[0] = num[QW-1:0];
  assign den_s[0] = den;
  assign quo_s[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0] r2;
    logic [DW:0] diff;
    logic        ge;
    assign r2   = {rem_s[i], low_s[i][QW-1]};
    assign diff = r2 - {1'b0, den_s[i]};
    assign ge   = r2 >= {1'b0, den_s[i]};

    // Shift in one numerator bit, subtract when it fits
    always_ff @(posedge clk) begin
      rem_s[i+1] <= ge ? diff[DW-1:0] : r2[DW-1:0];
      low_s[i+1] <= low_s[i] << 1;
      den_s[i+1] <= den_s[i];
      quo_s[i+1] <= {quo_s[i][QW-2:0], ge};
    end
  end

  assign quo = quo_s[QW];

endmodule

`default_nettype wire

/* hw/rtl/vara_norm.sv */
// Normalizes one integer 3D vector to a Q30 unit vector.
// Depends on vara_pkg, vara_isqrt and vara_div.
`timescale 1ns / 1ps
`default_nettype none

module vara_norm import vara_pkg::*; #(
  parameter int IN_W = IN_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic signed [IN_W-1:0]   comp [3],
  output logic signed [UNIT_W-1:0] unit [3]
);

  localparam int SH_DLY = 34;
  localparam int SG_DLY = 66;

  logic [IN_W-1:0]   mag1 [3];
  logic [2:0]        sgn1;
  logic [IN_W-1:0]   mx;
  logic [6:0]        len;
  logic [5:0]        k;
  logic [SH_W-1:0]   sh2 [3];
  logic [2:0]        sgn2;
  logic [SQ_W-1:0]   sq3 [3];
  logic [SQ_W-1:0]   sq4;
  logic [ROOT_W-1:0] root;
  logic [SH_W-1:0]   shd [SH_DLY][3];
  logic [2:0]        sgd [SG_DLY];
  logic [UDIV_NW-1:0] num5 [3];
  logic [ROOT_W-1:0] den5;
  logic [UDIV_QW-1:0] q [3];

  // Take magnitudes and signs
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag1[i] <= comp[i][IN_W-1] ? IN_W'(-comp[i]) : IN_W'(comp[i]);
      sgn1[i] <= comp[i][IN_W-1];
    end
  end

  // Largest shift that keeps the biggest magnitude at or below 2^31
  always_comb begin
    mx = mag1[0];
    if (mag1[1] > mx) mx = mag1[1];
    if (mag1[2] > mx) mx = mag1[2];
    len = bitlen64(64'(mx) - 64'd1);
    k   = 6'(7'd31 - len);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sh2[i] <= SH_W'(64'(mag1[i]) << k);
      sq3[i] <= 64'(sh2[i]) * 64'(sh2[i]);
    end
    sgn2 <= sgn1;
    sq4  <= sq3[0] + sq3[1] + sq3[2];
  end

  vara_isqrt u_isqrt (
    .clk  (clk),
    .x    (sq4),
    .root (root)
  );

  // Hold magnitudes and signs beside the root and the divide
  always_ff @(posedge clk) begin
    shd[0] <= sh2;
    for (int j = 1; j < SH_DLY; j++) shd[j] <= shd[j-1];
    sgd[0] <= sgn2;
    for (int j = 1; j < SG_DLY; j++) sgd[j] <= sgd[j-1];
  end

  // Rounded quotient numerator
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      num5[i] <= (UDIV_NW'(shd[SH_DLY-1][i]) << UNIT_SH) + UDIV_NW'(root >> 1);
    end
    den5 <= root;
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    vara_div #(
      .NW (UDIV_NW),
      .DW (ROOT_W),
      .QW (UDIV_QW)
    ) u_div (
      .clk (clk),
      .num (num5[i]),
      .den (den5),
      .quo (q[i])
    );
  end

  // Restore signs
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      unit[i] <= sgd[SG_DLY-1][i] ? -$signed({1'b0, q[i]}) : $signed({1'b0, q[i]});
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/vara_mat.sv */
// Builds the rotation matrix from two Q30 unit vectors.
// Depends on vara_pkg and vara_div.
`timescale 1ns / 1ps
`default_nettype none

module vara_mat import vara_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic signed [UNIT_W-1:0]  ua [3],
  input  logic signed [UNIT_W-1:0]  ub [3],
  output logic signed [FRAC_BITS+1:0] r [9]
);

  localparam int OUT_W = FRAC_BITS + 2;
  localparam int RSH   = 60 - FRAC_BITS;
  localparam int V_DLY = 38;
  localparam int O_DLY = 36;
  localparam int N_DLY = 36;
  localparam int S_DLY = 32;
  localparam logic signed [63:0] HALF_U = 64'sd1 <<< (UNIT_SH - 1);
  localparam logic signed [ACC_W-1:0] ONE60  = ACC_W'(1) << 60;
  localparam logic signed [ACC_W-1:0] HALF_O = ACC_W'(1) << (RSH - 1);
  localparam logic signed [ACC_W-1:0] ONE_A  = ACC_W'(1) << FRAC_BITS;

  logic signed [63:0]     p [9];
  logic signed [V_W-1:0]  v2 [3];
  logic signed [V_W-1:0]  c2;
  logic signed [PROD_W-1:0] vv3 [6];
  logic signed [V_W-1:0]  omc3;
  logic signed [PROD_W-1:0] dsum;
  logic [63:0]            s2_4;
  logic signed [PROD_W-1:0] m4 [6];
  logic [6:0]             slen;
  logic [5:0]             t;
  logic [QDIV_DW-1:0]     den5;
  logic signed [FS_W-1:0] fs5 [6];
  logic [QDIV_NW-1:0]     num6 [6];
  logic [QDIV_DW-1:0]     den6;
  logic [5:0]             sgn6;
  logic [QDIV_QW-1:0]     qm [6];
  logic [5:0]             sd [S_DLY];
  logic signed [Q_W-1:0]  q7 [6];
  logic signed [V_W-1:0]  od [O_DLY];
  logic                   nz [N_DLY];
  logic signed [V_W-1:0]  vd [V_DLY][3];
  logic signed [TERM_W-1:0] term8 [6];

  // Cross and dot partial products
  always_ff @(posedge clk) begin
    p[0] <= 64'(ua[1]) * 64'(ub[2]);
    p[1] <= 64'(ua[2]) * 64'(ub[1]);
    p[2] <= 64'(ua[2]) * 64'(ub[0]);
    p[3] <= 64'(ua[0]) * 64'(ub[2]);
    p[4] <= 64'(ua[0]) * 64'(ub[1]);
    p[5] <= 64'(ua[1]) * 64'(ub[0]);
    p[6] <= 64'(ua[0]) * 64'(ub[0]);
    p[7] <= 64'(ua[1]) * 64'(ub[1]);
    p[8] <= 64'(ua[2]) * 64'(ub[2]);
  end

  // Round v and c back to Q30
  always_ff @(posedge clk) begin
    v2[0] <= V_W'((p[0] - p[1] + HALF_U) >>> UNIT_SH);
    v2[1] <= V_W'((p[2] - p[3] + HALF_U) >>> UNIT_SH);
    v2[2] <= V_W'((p[4] - p[5] + HALF_U) >>> UNIT_SH);
    c2    <= V_W'((p[6] + p[7] + p[8] + HALF_U) >>> UNIT_SH);
  end

  // Products of v components and 1 - c
  always_ff @(posedge clk) begin
    vv3[0] <= PROD_W'(v2[0]) * PROD_W'(v2[0]);
    vv3[1] <= PROD_W'(v2[1]) * PROD_W'(v2[1]);
    vv3[2] <= PROD_W'(v2[2]) * PROD_W'(v2[2]);
    vv3[3] <= PROD_W'(v2[0]) * PROD_W'(v2[1]);
    vv3[4] <= PROD_W'(v2[0]) * PROD_W'(v2[2]);
    vv3[5] <= PROD_W'(v2[1]) * PROD_W'(v2[2]);
    omc3   <= (V_W'(1) <<< UNIT_SH) - c2;
  end

  // s^2 and the numerators of the quadratic term
  assign dsum = vv3[0] + vv3[1] + vv3[2];

  always_ff @(posedge clk) begin
    s2_4 <= dsum[63:0];
    for (int i = 0; i < 3; i++) m4[i] <= vv3[i] - dsum;
    for (int i = 3; i < 6; i++) m4[i] <= vv3[i];
  end

  // Scale s^2 into 32 bits
  always_comb begin
    slen = bitlen64(s2_4);
    t    = (slen > 7'd32) ? 6'(slen - 7'd32) : 6'd0;
  end

  always_ff @(posedge clk) begin
    den5 <= QDIV_DW'(s2_4 >> t);
    for (int i = 0; i < 6; i++) fs5[i] <= FS_W'(m4[i] >>> t);
  end

  // Magnitude numerators with half divisor for rounding
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      num6[i] <= (QDIV_NW'(fs5[i][FS_W-1] ? FS_W'(-fs5[i]) : FS_W'(fs5[i])) << UNIT_SH)
                 + QDIV_NW'(den5 >> 1);
      sgn6[i] <= fs5[i][FS_W-1];
    end
    den6 <= den5;
  end

  for (genvar i = 0; i < 6; i++) begin : g_div
    vara_div #(
      .NW (QDIV_NW),
      .DW (QDIV_DW),
      .QW (QDIV_QW)
    ) u_div (
      .clk (clk),
      .num (num6[i]),
      .den (den6),
      .quo (qm[i])
    );
  end

  // Hold side values until the divide is done
  always_ff @(posedge clk) begin
    sd[0] <= sgn6;
    for (int j = 1; j < S_DLY; j++) sd[j] <= sd[j-1];
    od[0] <= omc3;
    for (int j = 1; j < O_DLY; j++) od[j] <= od[j-1];
    nz[0] <= s2_4 != '0;
    for (int j = 1; j < N_DLY; j++) nz[j] <= nz[j-1];
    vd[0] <= v2;
    for (int j = 1; j < V_DLY; j++) vd[j] <= vd[j-1];
  end

  // Signed quotient, then scale by 1 - c
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      q7[i]    <= sd[S_DLY-1][i] ? -$signed({2'b00, qm[i]}) : $signed({2'b00, qm[i]});
      term8[i] <= TERM_W'(q7[i]) * TERM_W'(od[O_DLY-1]);
    end
  end

  // Sum, round and saturate each element
  for (genvar e = 0; e < 9; e++) begin : g_elem
    localparam int VS = VX_SIGN[e];
    localparam int VC = VX_COMP[e];
    localparam int TI = TERM_IDX[e];
    localparam bit DIAG = (e == 0) || (e == 4) || (e == 8);
    logic signed [ACC_W-1:0] vsel;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] rr;

    always_comb begin
      if (VS > 0) vsel = ACC_W'(vd[V_DLY-1][VC]);
      else if (VS < 0) vsel = -ACC_W'(vd[V_DLY-1][VC]);
      else vsel = '0;
      acc = (DIAG ? ONE60 : '0) + (vsel <<< UNIT_SH)
            + (nz[N_DLY-1] ? ACC_W'(term8[TI]) : '0);
      rr  = (acc + HALF_O) >>> RSH;
    end

    always_ff @(posedge clk) begin
      if (rr > ONE_A) r[e] <= OUT_W'(ONE_A);
      else if (rr < -ONE_A) r[e] <= OUT_W'(-ONE_A);
      else r[e] <= OUT_W'(rr);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/vector_align_rotation_matrix.sv */
// Top level of the vector alignment block: input registers, special-case
// detection and output registers. Depends on vara_pkg, vara_norm, vara_mat.
`timescale 1ns / 1ps
`default_nettype none

// Takes one word (two integer 3D vectors) in every clock cycle while busy is
// low and returns the rotation matrix that turns the first direction onto
// the second. The depth is set by the 32-step square root and 31-step divider
// of the normalizer and the 32-step divider of the matrix stage, all fully
// pipelined. The result is shown for exactly one cycle with done high; the
// receiver cannot stall it, so it must take it then. busy is high only during
// reset. Parallel, antiparallel or zero inputs give the identity; zero inputs
// also raise zero_vector.
module vector_align_rotation_matrix import vara_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [IN_WIDTH-1:0]  a_x,
  input  logic signed [IN_WIDTH-1:0]  a_y,
  input  logic signed [IN_WIDTH-1:0]  a_z,
  input  logic signed [IN_WIDTH-1:0]  b_x,
  input  logic signed [IN_WIDTH-1:0]  b_y,
  input  logic signed [IN_WIDTH-1:0]  b_z,
  output logic                        done,
  output logic signed [FRAC_BITS+1:0] r_00,
  output logic signed [FRAC_BITS+1:0] r_01,
  output logic signed [FRAC_BITS+1:0] r_02,
  output logic signed [FRAC_BITS+1:0] r_10,
  output logic signed [FRAC_BITS+1:0] r_11,
  output logic signed [FRAC_BITS+1:0] r_12,
  output logic signed [FRAC_BITS+1:0] r_20,
  output logic signed [FRAC_BITS+1:0] r_21,
  output logic signed [FRAC_BITS+1:0] r_22,
  output logic                        zero_vector
);

`include "assert_macros.svh"

  localparam int OUT_W    = FRAC_BITS + 2;
  localparam int PW       = 2 * IN_WIDTH;
  localparam int CORE_LAT = NORM_LAT + MAT_LAT;
  localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(1) << FRAC_BITS;

  logic                        accept;
  logic signed [IN_WIDTH-1:0]  a0 [3];
  logic signed [IN_WIDTH-1:0]  b0 [3];
  logic [CORE_LAT:0]           vld;
  flags_t                      fl_next;
  flags_t                      fl [CORE_LAT];
  logic signed [UNIT_W-1:0]    ua [3];
  logic signed [UNIT_W-1:0]    ub [3];
  logic signed [OUT_W-1:0]     mr [9];
  logic signed [OUT_W-1:0]     ro [9];

  assign busy   = rst;
  assign accept = start && !busy;

  // Capture the input word
  always_ff @(posedge clk) begin
    a0[0] <= a_x;
    a0[1] <= a_y;
    a0[2] <= a_z;
    b0[0] <= b_x;
    b0[1] <= b_y;
    b0[2] <= b_z;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[CORE_LAT-1:0], accept};
      done <= vld[CORE_LAT];
    end
  end

  // Detect zero vectors and a zero integer cross product
  always_comb begin
    fl_next.zero = (a0[0] == '0 && a0[1] == '0 && a0[2] == '0) ||
                   (b0[0] == '0 && b0[1] == '0 && b0[2] == '0);
    fl_next.ident = fl_next.zero ||
      ((PW'(a0[1]) * PW'(b0[2]) == PW'(a0[2]) * PW'(b0[1])) &&
       (PW'(a0[2]) * PW'(b0[0]) == PW'(a0[0]) * PW'(b0[2])) &&
       (PW'(a0[0]) * PW'(b0[1]) == PW'(a0[1]) * PW'(b0[0])));
  end

  always_ff @(posedge clk) begin
    fl[0] <= fl_next;
    for (int j = 1; j < CORE_LAT; j++) fl[j] <= fl[j-1];
  end

  vara_norm #(.IN_W(IN_WIDTH)) u_norm_a (
    .clk  (clk),
    .comp (a0),
    .unit (ua)
  );

  vara_norm #(.IN_W(IN_WIDTH)) u_norm_b (
    .clk  (clk),
    .comp (b0),
    .unit (ub)
  );

  vara_mat #(.FRAC_BITS(FRAC_BITS)) u_mat (
    .clk (clk),
    .ua  (ua),
    .ub  (ub),
    .r   (mr)
  );

  // Drop in the identity for special cases
  always_ff @(posedge clk) begin
    for (int e = 0; e < 9; e++) begin
      if (fl[CORE_LAT-1].ident) begin
        ro[e] <= (e == 0 || e == 4 || e == 8) ? ONE_OUT : '0;
      end else begin
        ro[e] <= mr[e];
      end
    end
    zero_vector <= fl[CORE_LAT-1].zero;
  end

  assign r_00 = ro[0];
  assign r_01 = ro[1];
  assign r_02 = ro[2];
  assign r_10 = ro[3];
  assign r_11 = ro[4];
  assign r_12 = ro[5];
  assign r_20 = ro[6];
  assign r_21 = ro[7];
  assign r_22 = ro[8];

  `VARA_ASSERT_NEXT(done_follows_a, vld[CORE_LAT], done)
  `VARA_ASSERT(zero_diag_a, done && zero_vector, r_00 == ONE_OUT && r_11 == ONE_OUT && r_22 == ONE_OUT)
  `VARA_ASSERT(zero_off_a, done && zero_vector, r_01 == '0 && r_12 == '0 && r_20 == '0)
  `VARA_ASSERT(range_a, done, r_00 <= ONE_OUT && r_00 >= -ONE_OUT && r_11 <= ONE_OUT && r_11 >= -ONE_OUT)

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking bench for vector_align_rotation_matrix: drives vector pairs, predicts
// each rotation matrix with a bit-exact fixed-point model and checks every done word.
// Depends on vara_pkg and the RTL of the block.
`timescale 1ns / 1ps

class align_scoreboard;
  typedef struct {
    logic signed [15:0] r [9];
    logic               zv;
  } matrix_word_t;

  matrix_word_t expected_q [$];
  int           errors;

  function new();
    errors = 0;
  endfunction

  // Integer square root, floor
  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (x >= res + bit_w) begin
        x = x - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // Scale the vector up, then divide by its length into Q30
  function automatic void unit_q30(input longint vec [3], output longint u [3]);
    longint unsigned m, sq, n, q;
    longint unsigned mag [3];
    int k;
    m = 0;
    sq = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec[i] < 0 ? longint'(-vec[i]) : longint'(vec[i]);
      if (mag[i] > m) m = mag[i];
    end
    while (k < 40 && (m << (k + 1)) <= (64'd1 << 31)) k++;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] << k;
      sq += mag[i] * mag[i];
    end
    n = isqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 30) + n / 2) / n;
      u[i] = vec[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic longint rnd30(input longint x);
    return (x + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint div_nearest(input longint num, input longint den);
    longint unsigned mag, q;
    mag = num < 0 ? longint'(-num) : longint'(num);
    q = (mag + longint'(den) / 2) / longint'(den);
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Compute the aligning rotation for one word
  function automatic matrix_word_t predict_rotation(input logic signed [15:0] in_w [6]);
    matrix_word_t w;
    longint a [3], b [3], ua [3], ub [3], v [3], vx [9];
    longint c, s2, omc, r, mij, den, q;
    bit zf, ident;
    int t;
    for (int i = 0; i < 3; i++) begin
      a[i] = in_w[i];
      b[i] = in_w[i + 3];
    end
    zf = (a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0);
    ident = zf || (a[1] * b[2] == a[2] * b[1] && a[2] * b[0] == a[0] * b[2] &&
                   a[0] * b[1] == a[1] * b[0]);
    w.zv = zf;
    if (ident) begin
      for (int e = 0; e < 9; e++) w.r[e] = (e % 4 == 0) ? 16'sd16384 : 16'sd0;
      return w;
    end
    unit_q30(a, ua);
    unit_q30(b, ub);
    v[0] = rnd30(ua[1] * ub[2] - ua[2] * ub[1]);
    v[1] = rnd30(ua[2] * ub[0] - ua[0] * ub[2]);
    v[2] = rnd30(ua[0] * ub[1] - ua[1] * ub[0]);
    c = rnd30(ua[0] * ub[0] + ua[1] * ub[1] + ua[2] * ub[2]);
    s2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    omc = (64'sd1 <<< 30) - c;
    vx = '{0, -v[2], v[1], v[2], 0, -v[0], -v[1], v[0], 0};
    t = 0;
    while ((longint'(s2) >> t) >= (64'd1 << 32)) t++;
    den = longint'(longint'(s2) >> t);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r = (i == j ? (64'sd1 <<< 60) : 64'sd0) + vx[i * 3 + j] * (64'sd1 <<< 30);
        if (s2 != 0) begin
          mij = v[i] * v[j] - (i == j ? s2 : 64'sd0);
          q = div_nearest((mij >>> t) * (64'sd1 <<< 30), den);
          r += q * omc;
        end
        r = (r + (64'sd1 <<< 45)) >>> 46;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        w.r[i * 3 + j] = r[15:0];
      end
    end
    return w;
  endfunction

  function void note_word(input logic signed [15:0] in_w [6]);
    expected_q = {expected_q, predict_rotation(in_w)};
  endfunction

  function void check_word(input logic signed [15:0] got [9], input logic got_zv);
    matrix_word_t w;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result word", $time);
      errors++;
      return;
    end
    w = expected_q.pop_front();
    for (int e = 0; e < 9; e++) begin
      if (got[e] !== w.r[e]) begin
        $display("%0t: r_%0d%0d expected %0d actual %0d", $time, e / 3, e % 3,
                 w.r[e], got[e]);
        errors++;
      end
    end
    if (got_zv !== w.zv) begin
      $display("%0t: zero_vector expected %0b actual %0b", $time, w.zv, got_zv);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  import vara_pkg::*;

  logic clk, rst, start, busy, done, zero_vector;
  logic signed [15:0] a_x, a_y, a_z, b_x, b_y, b_z;
  logic signed [15:0] r_00, r_01, r_02, r_10, r_11, r_12, r_20, r_21, r_22;

  align_scoreboard sb;

  vector_align_rotation_matrix u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .done(done),
    .r_00(r_00), .r_01(r_01), .r_02(r_02), .r_10(r_10), .r_11(r_11), .r_12(r_12),
    .r_20(r_20), .r_21(r_21), .r_22(r_22), .zero_vector(zero_vector)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    sb = new();
  end

  // Check every word shown with done
  always @(posedge clk) begin
    logic signed [15:0] got [9];
    got = '{r_00, r_01, r_02, r_10, r_11, r_12, r_20, r_21, r_22};
    if (!rst && done) sb.check_word(got, zero_vector);
  end

  // Offer one word and hold it until taken
  task automatic send_pair(input logic signed [15:0] in_w [6]);
    start <= 1'b1;
    a_x <= in_w[0]; a_y <= in_w[1]; a_z <= in_w[2];
    b_x <= in_w[3]; b_y <= in_w[4]; b_z <= in_w[5];
    do @(posedge clk); while (busy);
    sb.note_word(in_w);
  endtask

  // Drop start for a random gap, unless in the no-idle stretch
  task automatic maybe_idle(input int idx);
    if (idx < 600 || idx > 900) begin
      while ($urandom_range(99) < 27) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  function automatic logic signed [15:0] small_val();
    return 16'($signed($urandom_range(0, 40)) - 20);
  endfunction

  initial begin
    logic signed [15:0] w [6];
    logic signed [15:0] directed [20][6];
    int mode, k;
    directed = '{
      '{0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 1, 2, 3},
      '{5, -7, 9, 0, 0, 0},
      '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff},
      '{16'sh7fff, 0, 0, 0, 16'sh7fff, 0},
      '{16'sh8000, 0, 0, 0, 0, 16'sh8000},
      '{1, 0, 0, 0, 1, 0},
      '{1, 0, 0, -1, 0, 0},
      '{3, 4, 5, 6, 8, 10},
      '{3, 4, 5, -6, -8, -10},
      '{16'sh7fff, 1, 0, 16'sh7fff, 0, 0},
      '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7ffe},
      '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff},
      '{1, 1, 1, -1, -1, 1},
      '{0, 0, 1, 0, 0, -1},
      '{16'shffff, 0, 0, 0, 0, 1},
      '{2, 0, 0, -1, 1, 0},
      '{16'sh8000, 16'sh8000, 0, 16'sh7fff, 16'sh8000, 0},
      '{1, 2, 3, 3, 2, 1},
      '{100, -200, 300, -300, 200, 101}
    };
    rst = 1'b1;
    start = 1'b0;
    {a_x, a_y, a_z, b_x, b_y, b_z} = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 20; i++) begin
      send_pair(directed[i]);
      maybe_idle(i);
    end
    for (int i = 0; i < 1500; i++) begin
      mode = $urandom_range(99);
      for (int j = 0; j < 6; j++) w[j] = 16'($urandom);
      if (mode < 15) begin
        for (int j = 0; j < 6; j++) w[j] = small_val();
      end else if (mode < 30) begin
        // near-parallel or antiparallel pairs
        k = $urandom_range(1) ? 1 : -1;
        for (int j = 0; j < 3; j++) begin
          w[j] = 16'($signed($urandom_range(0, 20000)) - 10000);
          w[j + 3] = 16'(k * w[j] + small_val());
        end
      end else if (mode < 35) begin
        k = $urandom_range(1) ? 0 : 3;
        for (int j = 0; j < 3; j++) w[j + k] = 0;
      end else if (mode < 40) begin
        k = $urandom_range(1, 3);
        for (int j = 0; j < 3; j++) w[j + 3] = 16'(k * small_val());
        for (int j = 0; j < 3; j++) w[j] = 16'(w[j + 3] * 2);
      end
      send_pair(w);
      if (i == 1000) begin
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(posedge clk);
      end else begin
        maybe_idle(i);
      end
    end
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Global timeout
  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
